// File: src/hcs_pkg.sv
// ----------------------------------------------------------------------------
// Hamiltonian cycle search package
// Shared widths, operation codes, sequencer states and the adjacency command.
// ----------------------------------------------------------------------------
package hcs_pkg;

  localparam int VERTEX_W = 4;
  localparam int OP_W     = 2;
  localparam int COUNT_W  = 4;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_SEARCH   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRY,
    S_BACK_POP,
    S_BACK_PREV,
    S_EMIT
  } search_state_t;

  typedef struct packed {
    logic                add;
    logic                clear;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
  } adj_cmd_t;

endpackage

// File: src/hcs_in_if.sv
// ----------------------------------------------------------------------------
// Hamiltonian cycle search input channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface hcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [hcs_pkg::OP_W-1:0]      operation;
  logic [hcs_pkg::VERTEX_W-1:0]  from_vertex;
  logic [hcs_pkg::VERTEX_W-1:0]  to_vertex;

  modport source (output valid, output operation, output from_vertex, output to_vertex,
                  input ready);
  modport sink (input valid, input operation, input from_vertex, input to_vertex,
                output ready);
endinterface

// File: src/hcs_out_if.sv
// ----------------------------------------------------------------------------
// Hamiltonian cycle search output channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface hcs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [hcs_pkg::VERTEX_W-1:0]  vertex;
  logic                          last;

  modport source (output valid, output found, output vertex, output last, input ready);
  modport sink (input valid, input found, input vertex, input last, output ready);
endinterface

// File: src/hcs_adjacency.sv
// ----------------------------------------------------------------------------
// Hamiltonian cycle search adjacency store
// Bit matrix of directed edges with add, clear and a single edge query.
// ----------------------------------------------------------------------------
module hcs_adjacency #(
  parameter int MAX_VERTICES = 10,
  parameter int VW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  hcs_pkg::adj_cmd_t cmd,
  input  logic [VW-1:0]     query_row,
  input  logic [VW-1:0]     query_col,
  output logic              query_edge
);

  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
  logic                    add_ok;

  assign add_ok = cmd.add && (cmd.from_vertex < MAX_VERTICES) &&
                  (cmd.to_vertex < MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        rows[r] <= '0;
      end
    end else if (add_ok) begin
      rows[cmd.from_vertex[VW-1:0]][cmd.to_vertex[VW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    query_edge = 1'b0;
    if ((query_row < MAX_VERTICES) && (query_col < MAX_VERTICES)) begin
      query_edge = rows[query_row][query_col];
    end
  end

endmodule

// File: src/hcs_search.sv
// ----------------------------------------------------------------------------
// Hamiltonian cycle search sequencer
// Depth-first walk over vertex orderings with one edge test per cycle outside
// backtracking, then streams the cycle found, or a single not-found result.
// ----------------------------------------------------------------------------
module hcs_search #(
  parameter int MAX_VERTICES = 10,
  parameter int VW = 4,
  parameter int CW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [CW-1:0] vertex_limit,
  output logic          busy,
  output logic [VW-1:0] query_row,
  output logic [VW-1:0] query_col,
  input  logic          query_edge,
  hcs_out_if.source     out_ch
);

  localparam int VertexW = hcs_pkg::VERTEX_W;

  hcs_pkg::search_state_t state, state_next;

  logic [VW-1:0]           ordering [MAX_VERTICES];
  logic [CW-1:0]           count, count_next;
  logic [CW-1:0]           depth, depth_next;
  logic [CW-1:0]           cand, cand_next;
  logic [CW-1:0]           idx, idx_next;
  logic [MAX_VERTICES-1:0] used, used_next;
  logic [VW-1:0]           prev, prev_next;
  logic [VW-1:0]           first, first_next;
  logic                    found, found_next;
  logic                    wr_en;
  logic [VW-1:0]           rd_addr;
  logic [VW-1:0]           rd_data;
  logic [CW-1:0]           depth_m1;
  logic                    cand_ok;
  logic                    at_end;

  assign depth_m1 = depth - 1'b1;
  assign rd_data  = ordering[rd_addr];
  assign at_end   = (idx == count);
  assign busy     = (state != hcs_pkg::S_IDLE);

  assign query_row = prev;
  assign query_col = (depth == count) ? first : cand[VW-1:0];
  assign cand_ok   = !used[cand[VW-1:0]] && ((depth == '0) || query_edge);

  assign out_ch.valid  = (state == hcs_pkg::S_EMIT);
  assign out_ch.found  = found;
  assign out_ch.last   = !found || at_end;
  assign out_ch.vertex = !found ? '0 : (at_end ? VertexW'(first) : VertexW'(rd_data));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    count <= count_next;
    depth <= depth_next;
    cand  <= cand_next;
    idx   <= idx_next;
    used  <= used_next;
    prev  <= prev_next;
    first <= first_next;
    found <= found_next;
    if (wr_en) begin
      ordering[depth[VW-1:0]] <= cand[VW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    depth_next = depth;
    cand_next  = cand;
    idx_next   = idx;
    used_next  = used;
    prev_next  = prev;
    first_next = first;
    found_next = found;
    wr_en      = 1'b0;
    rd_addr    = depth_m1[VW-1:0];
    case (state)
      hcs_pkg::S_IDLE: begin
        if (start) begin
          count_next = vertex_limit;
          depth_next = '0;
          cand_next  = '0;
          idx_next   = '0;
          used_next  = '0;
          found_next = 1'b0;
          state_next = (vertex_limit == '0) ? hcs_pkg::S_EMIT : hcs_pkg::S_TRY;
        end
      end
      hcs_pkg::S_TRY: begin
        if (depth == count) begin
          if (query_edge) begin
            found_next = 1'b1;
            state_next = hcs_pkg::S_EMIT;
          end else begin
            state_next = hcs_pkg::S_BACK_POP;
          end
        end else if (cand == count) begin
          state_next = (depth == '0) ? hcs_pkg::S_EMIT : hcs_pkg::S_BACK_POP;
        end else if (cand_ok) begin
          wr_en                     = 1'b1;
          used_next[cand[VW-1:0]]   = 1'b1;
          prev_next                 = cand[VW-1:0];
          if (depth == '0) begin
            first_next = cand[VW-1:0];
          end
          depth_next = depth + 1'b1;
          cand_next  = '0;
        end else begin
          cand_next = cand + 1'b1;
        end
      end
      hcs_pkg::S_BACK_POP: begin
        used_next[rd_data] = 1'b0;
        cand_next          = CW'(rd_data) + 1'b1;
        depth_next         = depth_m1;
        state_next         = (depth_m1 == '0) ? hcs_pkg::S_TRY : hcs_pkg::S_BACK_PREV;
      end
      hcs_pkg::S_BACK_PREV: begin
        prev_next  = rd_data;
        state_next = hcs_pkg::S_TRY;
      end
      hcs_pkg::S_EMIT: begin
        rd_addr = idx[VW-1:0];
        if (out_ch.ready) begin
          if (out_ch.last) begin
            state_next = hcs_pkg::S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = hcs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: src/hamiltonian_cycle_search.sv
// ----------------------------------------------------------------------------
// Hamiltonian cycle search
// Holds a directed graph as an adjacency bit matrix and searches it for the
// first Hamiltonian cycle in lexicographic vertex order.
//
//   Channel | Direction | Payload
//   in_ch   | sink      | operation, from_vertex, to_vertex
//   out_ch  | source    | found, vertex, last
//   cfg     | write     | cfg_wr_en, cfg_wr_data (vertex count)
//
// A search tests candidate vertices one at a time with the edge-test unit,
// backtracks through S_BACK_POP and, above depth one, S_BACK_PREV each time
// the candidates at a depth run out, then streams its result transactions.
// Reset clears all edges and sets the vertex count to ten.
// The block accepts no input while a search runs or its results are stalled.
// ----------------------------------------------------------------------------
module hamiltonian_cycle_search #(
  parameter int MAX_VERTICES = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [hcs_pkg::COUNT_W-1:0]  cfg_wr_data,
  hcs_in_if.sink                       in_ch,
  hcs_out_if.source                    out_ch
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int CountW = hcs_pkg::COUNT_W;

  logic [CountW-1:0]  vertex_count;
  logic [CW-1:0]      vertex_limit;
  logic               accept;
  logic               busy;
  logic               start;
  logic [VW-1:0]      query_row;
  logic [VW-1:0]      query_col;
  logic               query_edge;
  hcs_pkg::adj_cmd_t  adj_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= hcs_pkg::VERTEX_COUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  assign vertex_limit = (vertex_count > CountW'(MAX_VERTICES)) ?
                        CW'(MAX_VERTICES) : CW'(vertex_count);

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    adj_cmd.add         = 1'b0;
    adj_cmd.clear       = 1'b0;
    adj_cmd.from_vertex = in_ch.from_vertex;
    adj_cmd.to_vertex   = in_ch.to_vertex;
    start               = 1'b0;
    case (hcs_pkg::op_t'(in_ch.operation))
      hcs_pkg::OP_ADD_EDGE: adj_cmd.add   = accept;
      hcs_pkg::OP_CLEAR:    adj_cmd.clear = accept;
      hcs_pkg::OP_SEARCH:   start         = accept;
      default: begin
        start = 1'b0;
      end
    endcase
  end

  hcs_adjacency #(
    .MAX_VERTICES(MAX_VERTICES),
    .VW(VW)
  ) u_adjacency (
    .clk(clk),
    .rst(rst),
    .cmd(adj_cmd),
    .query_row(query_row),
    .query_col(query_col),
    .query_edge(query_edge)
  );

  hcs_search #(
    .MAX_VERTICES(MAX_VERTICES),
    .VW(VW),
    .CW(CW)
  ) u_search (
    .clk(clk),
    .rst(rst),
    .start(start),
    .vertex_limit(vertex_limit),
    .busy(busy),
    .query_row(query_row),
    .query_col(query_col),
    .query_edge(query_edge),
    .out_ch(out_ch)
  );

endmodule
